>>> design/binary_to_decimal_ascii_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII converter
// Shared property forms, clocked on clk and disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/b2da_pkg.sv
// -----------------------------------------------------------------------------
// b2da_pkg
// Widths, constants, stage payload types and the shift-and-add-3 helpers of
// the binary to decimal ASCII converter.
// -----------------------------------------------------------------------------
package b2da_pkg;

	localparam int WIDTH   = 32;
	localparam int VALUE_W = 32;
	// Input bits at or above WIDTH are ignored; bits above the port are zero.
	localparam int NBITS   = (WIDTH < VALUE_W) ? WIDTH : VALUE_W;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int STEPS   = 8;
	localparam int NSTG    = (NBITS + STEPS - 1) / STEPS;
	localparam int PAD_W   = NSTG * STEPS;
	localparam int ASCII_W = 6;
	localparam int COUNT_W = 4;
	localparam int POS_W   = $clog2(DIGITS);

	localparam logic [3:0]         ADD_LIMIT  = 4'h5;
	localparam logic [3:0]         ADD_CORR   = 4'h3;
	localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'h30;

	// Payload of one conversion stage: partial BCD and the input bits still
	// to be shifted in, most significant first.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [PAD_W-1:0] bits;
	} dab_t;

	// Finished conversion with its decimal digit count.
	typedef struct packed {
		logic [BCD_W-1:0]   bcd;
		logic [COUNT_W-1:0] count;
	} conv_t;

	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		logic [3:0]       nib;
		res = bcd;
		for (int k = 0; k < DIGITS; k++) begin
			nib = bcd[4*k +: 4];
			if (nib >= ADD_LIMIT) begin
				res[4*k +: 4] = nib + ADD_CORR;
			end
		end
		return res;
	endfunction

	function automatic dab_t dabble_step(input dab_t d);
		dab_t             r;
		logic [BCD_W-1:0] adj;
		adj    = bcd_adjust(d.bcd);
		r.bcd  = {adj[BCD_W-2:0], d.bits[PAD_W-1]};
		r.bits = {d.bits[PAD_W-2:0], 1'b0};
		return r;
	endfunction

endpackage

>>> design/binary_to_decimal_ascii.sv
// -----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary number to decimal by shift-and-add-3 and
// emits its ASCII digits, most significant first, leading zeros suppressed.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | start, busy        | value
//   result   | strobe             | ascii_digit, digit_count, last_digit
//
// A number gives digit_count results (1 to 10) at the output; the
// serializer that emits one digit per cycle sets the sustained rate.
// The first digit reaches the ports through four conversion stages, the digit
// count stage and the serializer, each of which registers it once.
// The pipeline takes a new number every cycle until it backs up behind the
// serializer; busy is then high and start is ignored.
// arst_n clears all valid bits; results cannot be held off by the receiver.
// -----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [b2da_pkg::VALUE_W-1:0]  value,
	output logic                          strobe,
	output logic [b2da_pkg::ASCII_W-1:0]  ascii_digit,
	output logic [b2da_pkg::COUNT_W-1:0]  digit_count,
	output logic                          last_digit
);

	b2da_pkg::dab_t   dab_in;
	b2da_pkg::dab_t   dab_out;
	b2da_pkg::conv_t  conv;
	logic             dab_ready;
	logic             dab_valid;
	logic             cnt_ready;
	logic             conv_valid;
	logic             ser_ready;

	always_comb begin
		dab_in.bcd  = '0;
		dab_in.bits = b2da_pkg::PAD_W'(value[b2da_pkg::NBITS-1:0]);
	end

	assign busy = !dab_ready;

	b2da_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_data   (dab_in),
		.in_ready  (dab_ready),
		.out_valid (dab_valid),
		.out_data  (dab_out),
		.out_ready (cnt_ready)
	);

	b2da_count u_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dab_valid),
		.in_data   (dab_out),
		.in_ready  (cnt_ready),
		.out_valid (conv_valid),
		.out_data  (conv),
		.out_ready (ser_ready)
	);

	b2da_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (conv_valid),
		.in_data     (conv),
		.in_ready    (ser_ready),
		.strobe      (strobe),
		.ascii_digit (ascii_digit),
		.digit_count (digit_count),
		.last_digit  (last_digit)
	);

endmodule

>>> design/b2da_dabble.sv
// -----------------------------------------------------------------------------
// b2da_dabble
// Shift-and-add-3 pipeline: each register stage takes in eight input bits.
// -----------------------------------------------------------------------------
module b2da_dabble (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  b2da_pkg::dab_t    in_data,
	output logic              in_ready,
	output logic              out_valid,
	output b2da_pkg::dab_t    out_data,
	input  logic              out_ready
);

	logic [b2da_pkg::NSTG-1:0] valid_s;
	b2da_pkg::dab_t            data_s [b2da_pkg::NSTG];

	logic [b2da_pkg::NSTG:0]   adv;
	logic [b2da_pkg::NSTG-1:0] stg_vin;
	b2da_pkg::dab_t            stg_din  [b2da_pkg::NSTG];
	b2da_pkg::dab_t            stg_next [b2da_pkg::NSTG];

	// A stage may load when it is empty or its content moves on.
	always_comb begin
		adv[b2da_pkg::NSTG] = out_ready;
		for (int i = b2da_pkg::NSTG - 1; i >= 0; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
	end

	always_comb begin
		for (int i = 0; i < b2da_pkg::NSTG; i++) begin
			if (i == 0) begin
				stg_vin[i] = in_valid;
				stg_din[i] = in_data;
			end else begin
				stg_vin[i] = valid_s[i-1];
				stg_din[i] = data_s[i-1];
			end
			stg_next[i] = stg_din[i];
			for (int s = 0; s < b2da_pkg::STEPS; s++) begin
				stg_next[i] = b2da_pkg::dabble_step(stg_next[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 0; i < b2da_pkg::NSTG; i++) begin
				if (adv[i]) begin
					valid_s[i] <= stg_vin[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < b2da_pkg::NSTG; i++) begin
			if (adv[i] && stg_vin[i]) begin
				data_s[i] <= stg_next[i];
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[b2da_pkg::NSTG-1];
	assign out_data  = data_s[b2da_pkg::NSTG-1];

endmodule

>>> design/b2da_count.sv
// -----------------------------------------------------------------------------
// b2da_count
// Finds the number of significant decimal digits of a finished conversion.
// -----------------------------------------------------------------------------
module b2da_count (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  b2da_pkg::dab_t   in_data,
	output logic             in_ready,
	output logic             out_valid,
	output b2da_pkg::conv_t  out_data,
	input  logic             out_ready
);

	logic                              valid_s5;
	b2da_pkg::conv_t                   conv_s5;
	logic [b2da_pkg::COUNT_W-1:0]      count;

	// The highest nonzero digit sets the count; zero still has one digit.
	always_comb begin
		count = b2da_pkg::COUNT_W'(1);
		for (int k = 0; k < b2da_pkg::DIGITS; k++) begin
			if (in_data.bcd[4*k +: 4] != 4'h0) begin
				count = b2da_pkg::COUNT_W'(k + 1);
			end
		end
	end

	assign in_ready = !valid_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (in_ready) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			conv_s5.bcd   <= in_data.bcd;
			conv_s5.count <= count;
		end
	end

	assign out_valid = valid_s5;
	assign out_data  = conv_s5;

endmodule

>>> design/b2da_serial.sv
// -----------------------------------------------------------------------------
// b2da_serial
// Emits the digits of one conversion as ASCII, most significant first, one
// per cycle, and takes the next conversion on the cycle of the last digit.
// -----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_assert.svh"

module b2da_serial (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  b2da_pkg::conv_t               in_data,
	output logic                          in_ready,
	output logic                          strobe,
	output logic [b2da_pkg::ASCII_W-1:0]  ascii_digit,
	output logic [b2da_pkg::COUNT_W-1:0]  digit_count,
	output logic                          last_digit
);

	logic                          active_q;
	logic [b2da_pkg::BCD_W-1:0]    bcd_q;
	logic [b2da_pkg::COUNT_W-1:0]  count_q;
	logic [b2da_pkg::POS_W-1:0]    pos_q;
	logic                          load;
	logic [3:0]                    nib;

	assign in_ready = !active_q || (pos_q == '0);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (active_q && (pos_q == '0)) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q   <= in_data.bcd;
			count_q <= in_data.count;
			pos_q   <= b2da_pkg::POS_W'(in_data.count - 1'b1);
		end else if (active_q) begin
			pos_q   <= pos_q - 1'b1;
		end
	end

	assign nib         = bcd_q[4*pos_q +: 4];
	assign strobe      = active_q;
	assign ascii_digit = b2da_pkg::ASCII_ZERO + {2'b00, nib};
	assign digit_count = count_q;
	assign last_digit  = (pos_q == '0);

	`B2DA_ASSERT_NEXT(a_run_unbroken, strobe && !last_digit, strobe && $stable(digit_count), "digit run broken off")
	`B2DA_ASSERT_NOW(a_count_range, strobe, (digit_count != '0) && (digit_count <= b2da_pkg::COUNT_W'(b2da_pkg::DIGITS)), "digit count out of range")
	`B2DA_ASSERT_NOW(a_no_lead_zero, strobe && !last_digit && (pos_q == b2da_pkg::POS_W'(count_q - 1'b1)), ascii_digit != b2da_pkg::ASCII_ZERO, "leading zero emitted")

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_to_decimal_ascii. A driver feeds numbers from
// a queue with random gaps. A shift-and-add-3 predictor turns each accepted
// number into its expected ASCII digits, and a monitor checks every strobed
// digit against them in order.
// -----------------------------------------------------------------------------
module tb_top;

	localparam logic [5:0] CHAR_ZERO  = 6'h30;
	localparam int         MAX_DIGITS = 10;
	localparam int         NUM_RANDOM = 380;

	typedef struct {
		bit          drain;
		int unsigned gap;
		logic [31:0] num;
	} number_req_t;

	typedef struct {
		logic [5:0] ascii;
		logic [3:0] count;
		logic       last;
	} digit_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic        busy;
	logic [31:0] value  = '0;
	logic        strobe;
	logic [5:0]  ascii_digit;
	logic [3:0]  digit_count;
	logic        last_digit;

	number_req_t number_q[$];
	digit_t      digit_q[$];
	int unsigned idle_cnt   = 0;
	int unsigned mismatches = 0;
	bit          burst      = 1'b0;

	binary_to_decimal_ascii u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.strobe      (strobe),
		.ascii_digit (ascii_digit),
		.digit_count (digit_count),
		.last_digit  (last_digit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Double dabble over the low WIDTH bits, then one expected digit per
	// decimal place, most significant first, without leading zeros.
	function automatic void predict_digits(input logic [31:0] num);
		logic [63:0] src;
		logic [63:0] bcd;
		int          nbits;
		int          ndig;
		int          pos;
		digit_t      d;
		nbits = (b2da_pkg::WIDTH > 64) ? 64 : b2da_pkg::WIDTH;
		src   = {32'd0, num};
		if (nbits < 64) begin
			src &= (64'd1 << nbits) - 64'd1;
		end
		bcd = '0;
		for (int i = nbits - 1; i >= 0; i--) begin
			for (int k = 0; k < 16; k++) begin
				if (bcd[4*k +: 4] >= 4'd5) begin
					bcd += 64'd3 << (4 * k);
				end
			end
			bcd = {bcd[62:0], src[i]};
		end
		ndig = 1;
		for (int i = 16; i > 0; i--) begin
			if (bcd[4*(i-1) +: 4] != 4'd0) begin
				ndig = i;
				break;
			end
		end
		if (ndig > MAX_DIGITS) begin
			ndig = MAX_DIGITS;
		end
		for (int n = 0; n < ndig; n++) begin
			pos     = ndig - 1 - n;
			d.ascii = CHAR_ZERO + {2'b00, bcd[4*pos +: 4]};
			d.count = 4'(ndig);
			d.last  = (pos == 0);
			digit_q.push_back(d);
		end
	endfunction

	function automatic void add_number(input logic [31:0] num);
		number_req_t r;
		if ($urandom_range(0, 19) == 0) begin
			burst = !burst;
		end
		r.drain = 1'b0;
		r.gap   = burst ? 0 : $urandom_range(0, 18);
		r.num   = num;
		number_q.push_back(r);
	endfunction

	// The sender holds off until every outstanding digit has come out.
	function automatic void add_drain();
		number_req_t r;
		r.drain = 1'b1;
		r.gap   = 0;
		r.num   = '0;
		number_q.push_back(r);
	endfunction

	function automatic logic [31:0] random_number();
		longint unsigned lo;
		longint unsigned hi;
		int              ndig;
		int unsigned     pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			// Uniform over the digit count, then uniform within that length.
			ndig = $urandom_range(1, MAX_DIGITS);
			lo   = 1;
			repeat (ndig - 1) lo *= 10;
			hi = lo * 10 - 1;
			if (ndig == 1) begin
				lo = 0;
			end
			if (hi > 64'hffff_ffff) begin
				hi = 64'hffff_ffff;
			end
			return $urandom_range(32'(hi), 32'(lo));
		end else if (pick < 9) begin
			return $urandom();
		end else begin
			// Just around a power of ten, where the digit count changes.
			ndig = $urandom_range(1, MAX_DIGITS - 1);
			lo   = 1;
			repeat (ndig) lo *= 10;
			return 32'(lo + $urandom_range(0, 2) - 1);
		end
	endfunction

	// Driver: a transaction completes at an edge with start high and busy low.
	always @(posedge clk) begin : drive
		logic took;
		took = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				predict_digits(value);
				took     = 1'b1;
				idle_cnt = 0;
			end else if (!start) begin
				idle_cnt++;
			end
			if (took || !start) begin
				if (number_q.size() > 0 && number_q[0].drain) begin
					if (digit_q.size() == 0) begin
						void'(number_q.pop_front());
					end
					start <= 1'b0;
				end else if (number_q.size() > 0 && idle_cnt >= number_q[0].gap) begin
					start <= 1'b1;
					value <= number_q[0].num;
					void'(number_q.pop_front());
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch
		digit_t want;
		if (arst_n && strobe) begin
			if (digit_q.size() == 0) begin
				$display("%0t: unexpected digit: expected none, got ascii %0d count %0d last %0b",
					$time, ascii_digit, digit_count, last_digit);
				mismatches++;
			end else begin
				want = digit_q.pop_front();
				if (ascii_digit !== want.ascii) begin
					$display("%0t: ascii_digit expected %0d, got %0d",
						$time, want.ascii, ascii_digit);
					mismatches++;
				end
				if (digit_count !== want.count) begin
					$display("%0t: digit_count expected %0d, got %0d",
						$time, want.count, digit_count);
					mismatches++;
				end
				if (last_digit !== want.last) begin
					$display("%0t: last_digit expected %0b, got %0b",
						$time, want.last, last_digit);
					mismatches++;
				end
			end
		end
	end

	initial begin
		// Directed numbers: zero, single digits, both sides of most powers of ten,
		// digits of five and above everywhere, and the full 32-bit range.
		add_number(32'd0);
		add_number(32'd1);
		add_number(32'd5);
		add_number(32'd9);
		add_number(32'd10);
		add_number(32'd99);
		add_number(32'd100);
		add_number(32'd555);
		add_number(32'd999);
		add_number(32'd1000);
		add_number(32'd99999);
		add_number(32'd100000);
		add_number(32'd9999999);
		add_number(32'd10000000);
		add_number(32'd99999999);
		add_number(32'd100000000);
		add_number(32'd999999999);
		add_number(32'd1000000000);
		add_number(32'd2147483648);
		add_number(32'h5555_5555);
		add_number(32'haaaa_aaaa);
		add_number(32'd4294967294);
		add_number(32'hffff_ffff);
		add_drain();
		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == 150 || i == 300) begin
				add_drain();
			end
			add_number(random_number());
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(posedge clk);
		while (number_q.size() != 0 || start || digit_q.size() != 0);
		repeat (40) @(posedge clk);

		if (digit_q.size() != 0) begin
			$display("%0t: missing digits: expected %0d more, got none",
				$time, digit_q.size());
			mismatches++;
		end

		if (mismatches == 0) begin
			$display("binary_to_decimal_ascii test passed");
		end else begin
			$display("binary_to_decimal_ascii test failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("binary_to_decimal_ascii test failed");
		$finish;
	end

endmodule
